[hdl/pmg_pkg.sv]
// ----------------------------------------------------------------------------
// pmg_pkg
// Types and constants shared by the partition move gain engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pmg_pkg;

  localparam int NODES     = 4096;
  localparam int PARTS     = 8;
  localparam int NODE_W    = 12;
  localparam int PART_W    = 3;
  localparam int CNT_W     = 10;
  localparam int GAIN_W    = 11;
  localparam int MODE_W    = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1023);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD     = 2'd0,
    MODE_NEIGHBOR = 2'd1,
    MODE_END      = 2'd2
  } mode_t;

  typedef logic [CNT_W-1:0] count_t;
  typedef count_t [PARTS-1:0] count_vec_t;

endpackage

`default_nettype wire

[hdl/pmg_item_if.sv]
// ----------------------------------------------------------------------------
// pmg_item_if
// Request channel into the gain engine: valid/ready plus one input item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmg_item_if;
  logic                        valid;
  logic                        ready;
  logic [pmg_pkg::MODE_W-1:0]  mode;
  logic [pmg_pkg::NODE_W-1:0]  node_id;
  logic [pmg_pkg::NODE_W-1:0]  neighbor_id;
  logic [pmg_pkg::PART_W-1:0]  part_id;

  modport source (output valid, output mode, output node_id, output neighbor_id,
                  output part_id, input ready);
  modport sink   (input valid, input mode, input node_id, input neighbor_id,
                  input part_id, output ready);
endinterface

`default_nettype wire

[hdl/pmg_result_if.sv]
// ----------------------------------------------------------------------------
// pmg_result_if
// Result channel out of the gain engine: valid/ready plus one move report.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmg_result_if;
  logic                               valid;
  logic                               ready;
  logic [pmg_pkg::NODE_W-1:0]         moved_node;
  logic [pmg_pkg::PART_W-1:0]         home_part;
  logic [pmg_pkg::PART_W-1:0]         best_dest;
  logic signed [pmg_pkg::GAIN_W-1:0]  best_gain;
  logic                               wants_move;

  modport source (output valid, output moved_node, output home_part,
                  output best_dest, output best_gain, output wants_move,
                  input ready);
  modport sink   (input valid, input moved_node, input home_part,
                  input best_dest, input best_gain, input wants_move,
                  output ready);
endinterface

`default_nettype wire

[hdl/partition_move_gain.sv]
// ----------------------------------------------------------------------------
// partition_move_gain
// Gain engine for graph partition refinement with a node partition table.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not blocked. Load requests
// write a node's partition into a 4096-entry table. Neighbor requests read the
// neighbor's partition from the table, and the counter stage then bumps that
// partition's saturating counter. An end request reads the node's home
// partition when it is accepted; the counter stage then snapshots and clears
// the counters, and the result stage registers the best destination and gain
// onto the result channel. The pace is set by the single table port (one read
// or one write per cycle) feeding the counter update in the following stage.
// The whole pipeline, input included, holds while a finished result waits
// behind a result the receiver has not yet taken. The table has no reset;
// nodes must be loaded before they are looked up.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_move_gain (
  input  wire logic   clk,
  input  wire logic   rst,
  pmg_item_if.sink    item,
  pmg_result_if.source result
);

  logic [pmg_pkg::PART_W-1:0] part_mem [pmg_pkg::NODES];

  logic                        adv;
  logic                        acc;
  pmg_pkg::mode_t              in_mode;
  logic                        in_known;

  // table read stage
  logic                        s1_valid;
  pmg_pkg::mode_t              s1_mode;
  logic [pmg_pkg::NODE_W-1:0]  s1_node;
  logic [pmg_pkg::PART_W-1:0]  rd_part;

  pmg_pkg::count_vec_t         counts;

  // gain stage
  logic                        s2_valid;
  logic [pmg_pkg::NODE_W-1:0]  s2_node;
  logic [pmg_pkg::PART_W-1:0]  s2_home;
  pmg_pkg::count_vec_t         s2_counts;

  logic signed [pmg_pkg::GAIN_W-1:0] best_next;
  logic [pmg_pkg::PART_W-1:0]        dest_next;

  // freeze everything only when a result is ready and the output is blocked
  assign adv        = !(s2_valid && result.valid && !result.ready);
  assign item.ready = adv;
  assign acc        = item.valid && adv;
  assign in_mode    = pmg_pkg::mode_t'(item.mode);

  always_comb begin
    case (in_mode)
      pmg_pkg::MODE_LOAD,
      pmg_pkg::MODE_NEIGHBOR,
      pmg_pkg::MODE_END:  in_known = 1'b1;
      default:            in_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && in_known) begin
      if (in_mode == pmg_pkg::MODE_LOAD) begin
        part_mem[item.node_id] <= item.part_id;
      end else if (in_mode == pmg_pkg::MODE_NEIGHBOR) begin
        rd_part <= part_mem[item.neighbor_id];
      end else begin
        rd_part <= part_mem[item.node_id];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= acc && in_known && (in_mode != pmg_pkg::MODE_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode <= in_mode;
      s1_node <= item.node_id;
    end
  end

  // counter update or snapshot-and-clear
  always_ff @(posedge clk) begin
    if (rst) begin
      counts   <= '0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && (s1_mode == pmg_pkg::MODE_END);
      if (s1_valid) begin
        if (s1_mode == pmg_pkg::MODE_NEIGHBOR) begin
          if (counts[rd_part] != pmg_pkg::COUNT_MAX) begin
            counts[rd_part] <= counts[rd_part] + pmg_pkg::CNT_W'(1);
          end
        end else begin
          counts <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid && (s1_mode == pmg_pkg::MODE_END)) begin
      s2_node   <= s1_node;
      s2_home   <= rd_part;
      s2_counts <= counts;
    end
  end

  // best destination: ties go to the higher index, home is skipped
  always_comb begin
    logic signed [pmg_pkg::GAIN_W-1:0] home_cnt;
    logic signed [pmg_pkg::GAIN_W-1:0] g;
    logic                              found;
    home_cnt  = $signed({1'b0, s2_counts[s2_home]});
    best_next = '0;
    dest_next = '0;
    found     = 1'b0;
    for (int d = 0; d < pmg_pkg::PARTS; d++) begin
      g = $signed({1'b0, s2_counts[d]}) - home_cnt;
      if (pmg_pkg::PART_W'(d) != s2_home) begin
        if (!found || (g >= best_next)) begin
          best_next = g;
          dest_next = pmg_pkg::PART_W'(d);
          found     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv && s2_valid) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      result.moved_node <= s2_node;
      result.home_part  <= s2_home;
      result.best_dest  <= dest_next;
      result.best_gain  <= best_next;
      result.wants_move <= !best_next[pmg_pkg::GAIN_W-1] && (best_next != '0);
    end
  end

endmodule

`default_nettype wire

[tb/partition_move_gain_tb.sv]
// ----------------------------------------------------------------------------
// partition_move_gain_tb
// Self-checking bench for the partition move gain engine. Node loads,
// neighbor requests, end requests and noise go in over the request channel.
// A scoreboard keeps its own partition table and neighbor counters, works
// out the best move at every end request, and compares each result field by
// field. Both sides idle and stall at random, with one long result stall.
// ----------------------------------------------------------------------------
module partition_move_gain_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pmg_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int GAIN_LIMIT = (1 << (pmg_pkg::GAIN_W - 1)) - 1;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [pmg_pkg::MODE_W-1:0] mode;
    logic [pmg_pkg::NODE_W-1:0] node_id;
    logic [pmg_pkg::NODE_W-1:0] neighbor_id;
    logic [pmg_pkg::PART_W-1:0] part_id;
  } gain_request_t;

  typedef struct packed {
    logic [pmg_pkg::NODE_W-1:0]        moved_node;
    logic [pmg_pkg::PART_W-1:0]        home_part;
    logic [pmg_pkg::PART_W-1:0]        best_dest;
    logic signed [pmg_pkg::GAIN_W-1:0] best_gain;
    logic                              wants_move;
  } move_report_t;

  class gain_scoreboard;
    logic [pmg_pkg::PART_W-1:0] node_part [pmg_pkg::NODES];
    pmg_pkg::count_t            tally [pmg_pkg::PARTS];
    move_report_t               expected_moves [$];
    int                         errors;

    function new();
      errors = 0;
      foreach (tally[p]) tally[p] = '0;
    endfunction

    function int pending();
      return expected_moves.size();
    endfunction

    function move_report_t predict_move(logic [pmg_pkg::NODE_W-1:0] node);
      move_report_t m;
      int home_cnt;
      int g;
      int best;
      bit found;
      m.moved_node = node;
      m.home_part = node_part[node];
      m.best_dest = '0;
      home_cnt = int'(tally[m.home_part]);
      found = 0;
      best = 0;
      for (int d = 0; d < pmg_pkg::PARTS; d++) begin
        if (d == int'(m.home_part)) continue;
        g = int'(tally[d]) - home_cnt;
        // ties go to the higher index
        if (!found || g >= best) begin
          best = g;
          m.best_dest = pmg_pkg::PART_W'(d);
          found = 1;
        end
      end
      if (best > GAIN_LIMIT) best = GAIN_LIMIT;
      if (best < -GAIN_LIMIT) best = -GAIN_LIMIT;
      m.best_gain = pmg_pkg::GAIN_W'(best);
      m.wants_move = (best >= 1);
      foreach (tally[p]) tally[p] = '0;
      return m;
    endfunction

    function void note_request(gain_request_t r);
      logic [pmg_pkg::PART_W-1:0] p;
      case (r.mode)
        pmg_pkg::MODE_LOAD: node_part[r.node_id] = r.part_id;
        pmg_pkg::MODE_NEIGHBOR: begin
          p = node_part[r.neighbor_id];
          if (tally[p] != pmg_pkg::COUNT_MAX) tally[p] = tally[p] + 1'b1;
        end
        pmg_pkg::MODE_END:
          expected_moves.insert(expected_moves.size(), predict_move(r.node_id));
        default: ;
      endcase
    endfunction

    function void check_move(move_report_t got);
      move_report_t exp;
      if (expected_moves.size() == 0) begin
        $error("moved_node: no result expected, got %0d", got.moved_node);
        errors++;
        return;
      end
      exp = expected_moves.pop_front();
      if (got.moved_node !== exp.moved_node) begin
        $error("moved_node: expected %0d, got %0d", exp.moved_node, got.moved_node);
        errors++;
      end
      if (got.home_part !== exp.home_part) begin
        $error("home_part: expected %0d, got %0d", exp.home_part, got.home_part);
        errors++;
      end
      if (got.best_dest !== exp.best_dest) begin
        $error("best_dest: expected %0d, got %0d", exp.best_dest, got.best_dest);
        errors++;
      end
      if (got.best_gain !== exp.best_gain) begin
        $error("best_gain: expected %0d, got %0d", exp.best_gain, got.best_gain);
        errors++;
      end
      if (got.wants_move !== exp.wants_move) begin
        $error("wants_move: expected %0d, got %0d", exp.wants_move, got.wants_move);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  pmg_item_if   item_ch ();
  pmg_result_if result_ch ();

  partition_move_gain dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  gain_scoreboard             board;
  bit                         src_idle_on;
  bit                         sink_idle_on;
  bit                         hold_request;
  int                         requests_sent;
  bit                         loaded [pmg_pkg::NODES];
  logic [pmg_pkg::NODE_W-1:0] loaded_ids [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("partition_move_gain test failed");
    $finish;
  end

  // Result side: check accepted results, stall in bursts or on a long hold.
  initial begin
    int hold_cycles;
    move_report_t got;
    hold_cycles = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        got.moved_node = result_ch.moved_node;
        got.home_part  = result_ch.home_part;
        got.best_dest  = result_ch.best_dest;
        got.best_gain  = result_ch.best_gain;
        got.wants_move = result_ch.wants_move;
        board.check_move(got);
      end
      if (hold_request) begin
        hold_request = 0;
        hold_cycles = 250;
      end else if (hold_cycles == 0 && sink_idle_on && $urandom_range(0, 9) == 0) begin
        hold_cycles = $urandom_range(1, 17);
      end
      if (hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_request(logic [pmg_pkg::MODE_W-1:0] mode,
                              logic [pmg_pkg::NODE_W-1:0] node,
                              logic [pmg_pkg::NODE_W-1:0] nbr,
                              logic [pmg_pkg::PART_W-1:0] part);
    gain_request_t r;
    r = '{mode, node, nbr, part};
    if (src_idle_on && $urandom_range(0, 9) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.mode        <= mode;
    item_ch.node_id     <= node;
    item_ch.neighbor_id <= nbr;
    item_ch.part_id     <= part;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    board.note_request(r);
    if (mode != MODE_IGNORED) requests_sent++;
  endtask

  task automatic load_node(logic [pmg_pkg::NODE_W-1:0] node,
                           logic [pmg_pkg::PART_W-1:0] part);
    if (!loaded[node]) begin
      loaded[node] = 1;
      loaded_ids.insert(loaded_ids.size(), node);
    end
    send_request(pmg_pkg::MODE_LOAD, node, pmg_pkg::NODE_W'($urandom), part);
  endtask

  task automatic add_neighbor(logic [pmg_pkg::NODE_W-1:0] nbr);
    send_request(pmg_pkg::MODE_NEIGHBOR, pmg_pkg::NODE_W'($urandom), nbr,
                 pmg_pkg::PART_W'($urandom));
  endtask

  task automatic close_node(logic [pmg_pkg::NODE_W-1:0] node);
    send_request(pmg_pkg::MODE_END, node, pmg_pkg::NODE_W'($urandom),
                 pmg_pkg::PART_W'($urandom));
  endtask

  task automatic send_noise();
    send_request(MODE_IGNORED, pmg_pkg::NODE_W'($urandom), pmg_pkg::NODE_W'($urandom),
                 pmg_pkg::PART_W'($urandom));
  endtask

  function automatic logic [pmg_pkg::NODE_W-1:0] pick_loaded();
    return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
  endfunction

  // Drop valid and hold until every report is back.
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic random_traffic(int count);
    int goal;
    int kind;
    int n;
    logic [pmg_pkg::NODE_W-1:0] nbr;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      kind = $urandom_range(0, 99);
      if (loaded_ids.size() < 4 || kind < 15) begin
        repeat ($urandom_range(1, 3))
          load_node(pmg_pkg::NODE_W'($urandom), pmg_pkg::PART_W'($urandom));
      end else if (kind < 22) begin
        send_noise();
      end else if (kind < 27) begin
        // broken sequence: neighbors with no end, they carry into the next node
        repeat ($urandom_range(1, 4)) add_neighbor(pick_loaded());
      end else begin
        n = $urandom_range(0, 10);
        nbr = pick_loaded();
        repeat (n) begin
          if ($urandom_range(0, 3) != 0) nbr = pick_loaded();
          add_neighbor(nbr);
        end
        close_node(pick_loaded());
      end
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.mode = pmg_pkg::MODE_LOAD;
    item_ch.node_id = '0;
    item_ch.neighbor_id = '0;
    item_ch.part_id = '0;
    src_idle_on = 1;
    sink_idle_on = 1;
    hold_request = 0;
    requests_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    load_node(12'd0, 3'd0);
    load_node(12'hFFF, 3'd7);
    load_node(12'h555, 3'd5);
    load_node(12'hAAA, 3'd2);
    send_noise();
    // no neighbors: all gains zero, tie goes to the top partition
    close_node(12'd0);
    add_neighbor(12'd0);
    add_neighbor(12'd0);
    add_neighbor(12'hAAA);
    close_node(12'hFFF);
    add_neighbor(12'hFFF);
    add_neighbor(12'hFFF);
    add_neighbor(12'h555);
    add_neighbor(12'h555);
    add_neighbor(12'hAAA);
    close_node(12'hAAA);
    // neighbors mostly at home: negative gain
    add_neighbor(12'h555);
    add_neighbor(12'h555);
    add_neighbor(12'h555);
    add_neighbor(12'd0);
    close_node(12'h555);
    load_node(12'd0, 3'd6);
    add_neighbor(12'hFFF);
    close_node(12'd0);

    random_traffic(200);

    // long result stall with a steady sender, then a full drain
    src_idle_on = 0;
    hold_request = 1;
    random_traffic(50);
    drain();

    src_idle_on = 1;
    random_traffic(130);

    src_idle_on = 0;
    sink_idle_on = 0;
    random_traffic(170);

    drain();
    repeat (8) @(posedge clk);
    if (board.errors == 0)
      $display("partition_move_gain test passed");
    else
      $display("partition_move_gain test failed");
    $finish;
  end

endmodule
